[src/bsf_pkg.sv]
// Shared types and fixed constants of the box smoothing filter.
package bsf_pkg;

  // Sample and configuration widths.
  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 5;

  // Series sample counter, saturating.
  localparam int              SEEN_W   = 6;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

  // Half width after reset.
  localparam logic [CFG_W-1:0] HALF_WIDTH_RESET = 5'd1;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } bsf_state_t;

endpackage

[src/box_smoothing_filter_edge_clamp_unit.sv]
// Centred box smoothing filter with edge replication, memory-based datapath.

// Each sample word is written into a circular sample memory of 2*MAX_HALF_WIDTH+1
// entries. For every output the sequencer reads the 2w+1 window entries, one
// per cycle, through the single read port (positions before the series start
// take the first sample, positions past the end take the newest), then divides
// the window sum by 2w+1 with round-to-nearest in a bit-serial restoring
// divider, one quotient bit per cycle. Each output thus passes through the window
// reads, the read pipeline and the preparation step, the divider and the load of
// the output register. A word that produces no output (the first w of a series)
// is taken without leaving the idle state. A word flagged tlast produces min(n,w)+1
// outputs back to back, n being its position in the series.
// A new sample is taken while the last result still waits in the output
// register. Writing the half width aborts any series in progress.
module box_smoothing_filter_edge_clamp_unit
  import bsf_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration: half_width
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [31:0] sample_in
  input  logic                in_tlast,   // last_in
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,  // [31:0] smoothed_out
  output logic                out_tlast   // last_out
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int AGE_W = AW + 2;
  localparam int SUM_W = SAMPLE_W + AW;
  localparam int CW    = $clog2(SUM_W + 1);
  localparam int CMP_W = SEEN_W + AW;

  // Registers
  bsf_state_t            state_r, state_nxt;
  logic [CFG_W-1:0]      half_width_r, half_width_nxt;
  logic [SEEN_W-1:0]     seen_r, seen_nxt;
  logic [SEEN_W-1:0]     n_r, n_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [AW-1:0]         c_r, c_nxt;
  logic [AW-1:0]         j_r, j_nxt;
  logic                  last_r, last_nxt;
  logic [SAMPLE_W-1:0]   first_r, first_nxt;
  logic                  rd_vld_r;
  logic                  sel_first_r;
  logic [SAMPLE_W-1:0]   mem_q_r;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic [AW-1:0]         rem_r, rem_nxt;
  logic [SUM_W-1:0]      quo_r, quo_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  // Sample memory
  logic [SAMPLE_W-1:0]   mem [DEPTH];

  // Combinational helpers
  logic [CFG_W-1:0]      w_eff;
  logic [AW-1:0]         w_a;
  logic [AW-1:0]         div_d;
  logic [AW-1:0]         two_w;
  logic                  in_acc;
  logic                  issuing;
  logic signed [AGE_W-1:0] age_s;
  logic [AW-1:0]         age_c;
  logic                  use_first;
  logic signed [AW:0]    addr_diff;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wp_inc;
  logic                  n_ge_w;
  logic [AW:0]           div_t;
  logic                  div_ge;
  logic [SUM_W-1:0]      mag;
  logic                  out_free;

  // Effective half width and divisor 2w+1
  assign w_eff = (half_width_r > CFG_W'(MAX_HALF_WIDTH)) ? CFG_W'(MAX_HALF_WIDTH)
                                                          : half_width_r;
  assign w_a   = AW'(w_eff);
  assign div_d = {w_a[AW-2:0], 1'b1};
  assign two_w = {w_a[AW-2:0], 1'b0};

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Window position: oldest first, clamped at the newest sample
  assign issuing = (state_r == ST_SUM) && (j_r <= two_w);
  assign age_s   = AGE_W'(c_r) + AGE_W'(w_a) - AGE_W'(j_r);
  assign age_c   = age_s[AGE_W-1] ? '0 : age_s[AW-1:0];
  assign use_first = CMP_W'(age_c) > CMP_W'(n_r);

  // Circular address of the entry age_c words old
  assign addr_diff = $signed({1'b0, wp_r}) - $signed({1'b0, age_c});
  assign rd_addr   = addr_diff[AW] ? AW'(addr_diff + (AW+1)'(DEPTH)) : addr_diff[AW-1:0];
  assign wp_inc    = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;

  assign n_ge_w = seen_r >= SEEN_W'(w_eff);

  // Restoring division step
  assign div_t  = {rem_r, quo_r[SUM_W-1]};
  assign div_ge = div_t >= {1'b0, div_d};

  // Magnitude of the window sum plus half the divisor for rounding
  assign mag = (acc_r[SUM_W-1] ? ~acc_r : acc_r)
             + (acc_r[SUM_W-1] ? SUM_W'(w_eff) + 1'b1 : SUM_W'(w_eff));

  // Sequencer and datapath next-state logic
  always_comb begin
    state_nxt      = state_r;
    half_width_nxt = half_width_r;
    seen_nxt       = seen_r;
    n_nxt          = n_r;
    wp_nxt         = wp_r;
    c_nxt          = c_r;
    j_nxt          = j_r;
    last_nxt       = last_r;
    first_nxt      = first_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wp_nxt   = wp_inc;
          n_nxt    = seen_r;
          last_nxt = in_tlast;
          j_nxt    = '0;
          acc_nxt  = '0;
          if (seen_r == '0) begin
            first_nxt = in_tdata;
          end
          if (in_tlast) begin
            seen_nxt  = '0;
            c_nxt     = n_ge_w ? w_a : AW'(seen_r);
            state_nxt = ST_SUM;
          end else begin
            seen_nxt = (seen_r < SEEN_MAX) ? seen_r + 1'b1 : seen_r;
            c_nxt    = w_a;
            if (n_ge_w) begin
              state_nxt = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        if (issuing) begin
          j_nxt = j_r + 1'b1;
        end
        if (rd_vld_r) begin
          acc_nxt = acc_r + SUM_W'($signed(sel_first_r ? first_r : mem_q_r));
        end
        if (!issuing && !rd_vld_r) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        neg_nxt   = acc_r[SUM_W-1];
        quo_nxt   = mag;
        rem_nxt   = '0;
        cnt_nxt   = CW'(SUM_W);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? AW'(div_t - {1'b0, div_d}) : div_t[AW-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = neg_r ? (SAMPLE_W'(0) - quo_r[SAMPLE_W-1:0])
                                : quo_r[SAMPLE_W-1:0];
          out_last_nxt  = last_r && (c_r == '0);
          if (last_r && (c_r != '0)) begin
            c_nxt     = c_r - 1'b1;
            j_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Half width write restarts the series
    if (cfg_we) begin
      half_width_nxt = cfg_wdata;
      seen_nxt       = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      half_width_r <= HALF_WIDTH_RESET;
      seen_r       <= '0;
      wp_r         <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      half_width_r <= half_width_nxt;
      seen_r       <= seen_nxt;
      wp_r         <= wp_nxt;
      rd_vld_r     <= issuing;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    c_r         <= c_nxt;
    j_r         <= j_nxt;
    last_r      <= last_nxt;
    first_r     <= first_nxt;
    acc_r       <= acc_nxt;
    neg_r       <= neg_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    sel_first_r <= use_first;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wp_inc] <= in_tdata;
    end
    mem_q_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Read data only arrives while the window is being summed.
  a_rd_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SUM))
    else $error("window read data outside summing");

  // The divider leaves a remainder below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r < div_d))
    else $error("divider remainder out of range");

  // A word flagged last always starts a flush and ends the series count.
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast && !cfg_we) |=> (state_r == ST_SUM) && (seen_r == '0))
    else $error("last word did not start a flush");

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_tready) |=> (state_r == ST_EMIT))
    else $error("result register overwritten");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the box smoothing filter with edge clamping.
module tb_top
  import bsf_pkg::*;
();

  localparam int MAX_HW       = 16;
  localparam int HIST_DEPTH   = 2 * MAX_HW + 1;
  localparam int SETTLE_CYC   = 2 * HIST_DEPTH + 60;
  localparam int N_DIRECTED   = 23;
  localparam int N_PHASES     = 8;
  localparam int PHASE_WORDS  = 18;
  localparam int LONG_PHASE   = 3;
  localparam int LONG_WORDS   = 72;
  localparam int LONG_SERIES  = 66;
  localparam int RANDOM_PHASE = 6;
  localparam int REPORT_MAX   = 10;

  localparam logic [SAMPLE_W-1:0] SMP_MAX  = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SMP_MIN  = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0] SMP_ZERO = 32'h0000_0000;
  localparam logic [SAMPLE_W-1:0] SMP_NEG1 = 32'hFFFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SMP_ONE  = 32'h0001_0000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } smoothed_word_t;

  // One row of the directed table; typed rows carry the value every output must have.
  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                lst;
    logic                typed;
    logic [SAMPLE_W-1:0] val;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;    // [31:0] sample_in
  logic                in_tlast = 1'b0;  // last_in
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;        // [31:0] smoothed_out
  logic                out_tlast;        // last_out

  // Filter model state.
  logic [CFG_W-1:0]    half_width_model = HALF_WIDTH_RESET;
  logic [SAMPLE_W-1:0] sample_hist [HIST_DEPTH];
  logic [SEEN_W-1:0]   series_len = '0;
  logic [SAMPLE_W-1:0] series_first = '0;

  smoothed_word_t pending_smoothed [$];
  smoothed_word_t want_word;

  int mismatch_count = 0;
  int words_sent     = 0;
  int words_checked  = 0;
  int burst_left     = 0;
  int ready_hold     = 0;

  // Directed table, walked at the reset half width of one.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{SMP_MAX,      1'b1, 1'b1, SMP_MAX},
    '{SMP_MIN,      1'b1, 1'b1, SMP_MIN},
    '{SMP_ZERO,     1'b1, 1'b1, SMP_ZERO},
    '{SMP_MIN,      1'b0, 1'b1, SMP_MIN},
    '{SMP_MIN,      1'b0, 1'b1, SMP_MIN},
    '{SMP_MIN,      1'b1, 1'b1, SMP_MIN},
    '{SMP_MAX,      1'b0, 1'b1, SMP_MAX},
    '{SMP_MAX,      1'b0, 1'b1, SMP_MAX},
    '{SMP_MAX,      1'b1, 1'b1, SMP_MAX},
    '{SMP_MAX,      1'b0, 1'b0, SMP_ZERO},
    '{SMP_MIN,      1'b0, 1'b0, SMP_ZERO},
    '{SMP_MAX,      1'b0, 1'b0, SMP_ZERO},
    '{SMP_MIN,      1'b1, 1'b0, SMP_ZERO},
    '{SMP_NEG1,     1'b0, 1'b0, SMP_ZERO},
    '{SMP_ZERO,     1'b0, 1'b0, SMP_ZERO},
    '{SMP_ZERO,     1'b1, 1'b0, SMP_ZERO},
    '{32'h0000_0002, 1'b0, 1'b0, SMP_ZERO},
    '{SMP_ZERO,     1'b0, 1'b0, SMP_ZERO},
    '{SMP_ZERO,     1'b1, 1'b0, SMP_ZERO},
    '{SMP_ONE,      1'b0, 1'b0, SMP_ZERO},
    '{32'h0003_0000, 1'b1, 1'b0, SMP_ZERO},
    // Series left open: the next half width write aborts it.
    '{32'h5555_5555, 1'b0, 1'b0, SMP_ZERO},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, SMP_ZERO}
  };

  logic [CFG_W-1:0] phase_hw [N_PHASES] = '{
    5'd0, 5'd16, 5'd31, 5'd2, 5'd17, 5'd4, 5'd9, 5'd1
  };

  box_smoothing_filter_edge_clamp_unit #(
    .MAX_HALF_WIDTH(MAX_HW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Sample at a given age from the newest; ages before the series start read the first sample.
  function automatic logic [SAMPLE_W-1:0] aged_sample(int age, int newest);
    if (age < 0) age = 0;
    if (age > newest || age >= HIST_DEPTH) return series_first;
    return sample_hist[age];
  endfunction

  // Rounded mean of the 2w+1 samples centred on the given age.
  function automatic logic [SAMPLE_W-1:0] window_mean(int centre, int newest, int w);
    longint acc;
    longint div;
    longint q;
    acc = 0;
    div = 2 * w + 1;
    for (int k = -w; k <= w; k++) acc += longint'($signed(aged_sample(centre - k, newest)));
    if (acc >= 0) q = (acc + div / 2) / div;
    else q = -((-acc + div / 2) / div);
    return q[SAMPLE_W-1:0];
  endfunction

  // Advance the filter model by one sample and queue the smoothed words it releases.
  function automatic void smooth_word(logic [SAMPLE_W-1:0] smp, logic lst,
                                      logic typed, logic [SAMPLE_W-1:0] typed_val);
    int w;
    int newest;
    int start_age;
    smoothed_word_t sw;
    w = (half_width_model > MAX_HW) ? MAX_HW : int'(half_width_model);
    newest = int'(series_len);
    if (series_len == 0) series_first = smp;
    for (int i = HIST_DEPTH - 1; i > 0; i--) sample_hist[i] = sample_hist[i - 1];
    sample_hist[0] = smp;
    if (series_len < SEEN_MAX) series_len = series_len + 1'b1;
    if (!lst) begin
      if (newest >= w) begin
        sw.value = typed ? typed_val : window_mean(w, newest, w);
        sw.last = 1'b0;
        pending_smoothed.push_back(sw);
      end
    end else begin
      // The end of a series flushes every centre still outstanding.
      start_age = (newest >= w) ? w : newest;
      for (int a = start_age; a >= 0; a--) begin
        sw.value = typed ? typed_val : window_mean(a, newest, w);
        sw.last = (a == 0);
        pending_smoothed.push_back(sw);
      end
      series_len = '0;
    end
  endfunction

  // Offer one word in bursts with random gaps; the model advances on acceptance.
  task automatic send_word(logic [SAMPLE_W-1:0] smp, logic lst,
                           logic typed, logic [SAMPLE_W-1:0] typed_val);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    smooth_word(smp, lst, typed, typed_val);
    words_sent++;
    burst_left--;
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  // Stop offering words and let the filter run dry.
  task automatic settle_filter();
    if (burst_left != 0) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (pending_smoothed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Half width write; it also aborts any series in progress.
  task automatic write_half_width(logic [CFG_W-1:0] hw);
    cfg_we    <= 1'b1;
    cfg_wdata <= hw;
    @(posedge clk);
    cfg_we <= 1'b0;
    half_width_model = hw;
    series_len = '0;
  endtask

  // Random sample: extremes, full-range noise or a small step from the series level.
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] level);
    case ($urandom_range(0, 7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return $urandom();
      default: return level + $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  // Main stimulus.
  initial begin
    int budget;
    int series_words;
    int pos;
    int w_eff;
    logic [CFG_W-1:0] hw;
    logic [SAMPLE_W-1:0] level;
    for (int i = 0; i < HIST_DEPTH; i++) sample_hist[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_word(directed_rows[r].smp, directed_rows[r].lst,
                directed_rows[r].typed, directed_rows[r].val);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle_filter();
      hw = (ph == RANDOM_PHASE) ? CFG_W'($urandom_range(0, 31)) : phase_hw[ph];
      write_half_width(hw);
      w_eff = (hw > MAX_HW) ? MAX_HW : int'(hw);
      budget = (ph == LONG_PHASE) ? LONG_WORDS : PHASE_WORDS;
      // Series of random length; the last one may be cut short by the next write.
      while (budget > 0) begin
        if (ph == LONG_PHASE && budget == LONG_WORDS) series_words = LONG_SERIES;
        else if ($urandom_range(0, 3) == 0) series_words = $urandom_range(1, w_eff + 1);
        else series_words = $urandom_range(w_eff + 1, 2 * w_eff + 4);
        level = $urandom();
        pos = 0;
        while (pos < series_words && budget > 0) begin
          send_word(pick_sample(level), pos == series_words - 1, 1'b0, '0);
          pos++;
          budget--;
        end
      end
    end

    settle_filter();
    $display("Summary: %0d sample words sent, %0d smoothed words checked", words_sent,
             words_checked);
    $display("Summary: %0d half width settings including 0, 16 and saturating values,",
             N_PHASES + 1);
    $display("Summary: %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Result side stalls in runs of its own: long stalls, long open stretches and chatter.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_tready <= 1'b0;
          ready_hold <= $urandom_range(1, 10);
        end
        1: begin
          out_tready <= 1'b1;
          ready_hold <= $urandom_range(30, 80);
        end
        default: begin
          out_tready <= 1'($urandom_range(0, 1));
          ready_hold <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_smoothed.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("Mismatch: unexpected word data=%h last=%b", out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want_word = pending_smoothed.pop_front();
        words_checked++;
        if (out_tdata !== want_word.value || out_tlast !== want_word.last) begin
          if (mismatch_count < REPORT_MAX)
            $display("Mismatch: expected data=%h last=%b, got data=%h last=%b",
                     want_word.value, want_word.last, out_tdata, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
